@@ sv/glpf_pkg.sv @@
// Shared types and constants of the grid local peak finder.
// No dependencies; every other file of the block imports this package.
package glpf_pkg;

   localparam int MAX_ROWS     = 64;
   localparam int MAX_COLS     = 32;
   localparam int SAMPLE_BITS  = 16;

   // Widths fixed by the result fields and the configuration registers.
   localparam int ROW_BITS     = 6;
   localparam int COL_BITS     = 5;
   localparam int ROW_CNT_BITS = 7;
   localparam int COL_CNT_BITS = 6;
   localparam int RAM_DEPTH    = 1 << COL_BITS;

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 7;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_COUNT = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COL_COUNT = 1'd1;

   localparam logic [ROW_CNT_BITS-1:0] ROW_LIMIT = ROW_CNT_BITS'(MAX_ROWS);
   localparam logic [COL_CNT_BITS-1:0] COL_LIMIT = COL_CNT_BITS'(MAX_COLS);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [ROW_BITS-1:0]           row_type;
   typedef logic [COL_BITS-1:0]           col_type;

   // One column of the line buffers: the row above and the current row.
   typedef struct packed {
      sample_type up;
      sample_type mid;
   } line_entry_type;

   // A cell and its four orthogonal neighbours, as handed to the comparator.
   typedef struct packed {
      sample_type center;
      sample_type up;
      sample_type down;
      sample_type left;
      sample_type right;
   } nbr_type;

endpackage

@@ sv/glpf_channels.sv @@
// Valid/ready channel interfaces of the grid local peak finder.
// Depends on glpf_pkg for the payload types.
interface glpf_req_if;
   import glpf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface glpf_rsp_if;
   import glpf_pkg::*;

   logic    valid;
   logic    ready;
   row_type peak_row;
   col_type peak_col;
   logic    last_of_run;

   modport source (output valid, output peak_row, output peak_col, output last_of_run,
                   input ready);
   modport sink   (input valid, input peak_row, input peak_col, input last_of_run,
                   output ready);
endinterface

@@ sv/glpf_line_ram.sv @@
// Line buffer memory: one write port and two registered read ports.
// Each entry holds a column of the row above and of the current row; uses glpf_pkg.
module glpf_line_ram (
   input  logic                     clock,
   input  logic                     wr_en,
   input  glpf_pkg::col_type        wr_addr,
   input  glpf_pkg::line_entry_type wr_data,
   input  logic                     rd_en,
   input  glpf_pkg::col_type        rd_addr_a,
   input  glpf_pkg::col_type        rd_addr_b,
   output glpf_pkg::line_entry_type rd_data_a,
   output glpf_pkg::line_entry_type rd_data_b
);
   import glpf_pkg::*;

   line_entry_type mem [RAM_DEPTH];
   line_entry_type rd_data_a_ff;
   line_entry_type rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ sv/glpf_peak_cmp.sv @@
// Four-neighbour comparator: a cell is a peak when it is not below any neighbour.
// Uses glpf_pkg for the neighbourhood struct.
module glpf_peak_cmp (
   input  glpf_pkg::nbr_type nbr,
   output logic              hit
);
   import glpf_pkg::*;

   assign hit = (nbr.center >= nbr.up)   && (nbr.center >= nbr.down) &&
                (nbr.center >= nbr.left) && (nbr.center >= nbr.right);

endmodule

@@ sv/grid_local_peak_finder_core.sv @@
// Grid local peak finder, top level.
// Uses glpf_pkg, the channel interfaces, glpf_line_ram and glpf_peak_cmp.
//
// Samples of a grid arrive on the req_chan channel in row-major order; the grid
// size is set through the csr_ write port (row count at index 0, column count at
// index 1); the user must write it only while the block is idle, which the block
// itself does not enforce. Each (row, column) of a cell that is not below any of its
// four neighbours leaves on rsp_chan, in row-major order, with cells outside the grid
// taken as zero. The sample at (r,c) decides cell (r-1,c); the final sample of a grid
// also decides the whole last row and restarts at (0,0).
//
// Each sample is taken in S_IDLE, which reads its column from the line memory, and
// is compared and written back in S_EVAL, which places a non-final sample's result
// in the output register; no new sample is taken until S_IDLE returns. The last-row sweep
// reads the memory again, column by column in S_FREAD and S_FEVAL, and ends in S_FEND.
//
// Reset sets both counts to one and the position to (0,0); the line memory is not
// cleared, as stale entries only reach masked row-0 results. While the receiver stalls,
// the pending result waits in the output register and the block keeps working
// until it has a further result to place. last_of_run marks the final result of a sample.
module grid_local_peak_finder_core (
   input  logic                                clock,
   input  logic                                reset,
   glpf_req_if.sink                            req_chan,
   glpf_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_en,
   input  logic [glpf_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [glpf_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import glpf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_FREAD,
      S_FEVAL,
      S_FEND
   } state_type;

   state_type                state_ff, state_in;
   sample_type               x_ff, x_in;
   row_type                  r_ff, r_in;
   col_type                  c_ff, c_in;
   logic                     last_grid_ff, last_grid_in;
   sample_type               left_ff, left_in;
   row_type                  row_pos_ff, row_pos_in;
   col_type                  col_pos_ff, col_pos_in;
   logic                     pend_valid_ff, pend_valid_in;
   row_type                  pend_row_ff, pend_row_in;
   col_type                  pend_col_ff, pend_col_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   row_type                  rsp_row_ff, rsp_row_in;
   col_type                  rsp_col_ff, rsp_col_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [ROW_CNT_BITS-1:0]  row_count_ff, row_count_in;
   logic [COL_CNT_BITS-1:0]  col_count_ff, col_count_in;

   logic [ROW_CNT_BITS-1:0]  rows_eff;
   logic [COL_CNT_BITS-1:0]  cols_eff;
   row_type                  r_eff;
   col_type                  c_eff;
   logic [COL_CNT_BITS-1:0]  c_eff_next;
   logic [ROW_CNT_BITS-1:0]  r_eff_next;
   logic [COL_CNT_BITS-1:0]  c_ff_next;
   logic                     has_right;
   logic                     accept;
   logic                     out_free;

   logic                     ram_wr_en;
   line_entry_type           ram_wr_data;
   logic                     ram_rd_en;
   col_type                  ram_rd_addr_a;
   col_type                  ram_rd_addr_b;
   line_entry_type           ram_rd_data_a;
   line_entry_type           ram_rd_data_b;

   nbr_type                  nbr;
   logic                     hit;
   logic                     hit_row;

   glpf_line_ram u_line_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (c_ff),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   glpf_peak_cmp u_peak_cmp (
      .nbr (nbr),
      .hit (hit)
   );

   // A count of zero acts as one, and a count above the limit as the limit.
   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = ROW_CNT_BITS'(1);
      end else if (row_count_ff > ROW_LIMIT) begin
         rows_eff = ROW_LIMIT;
      end else begin
         rows_eff = row_count_ff;
      end
      if (col_count_ff == '0) begin
         cols_eff = COL_CNT_BITS'(1);
      end else if (col_count_ff > COL_LIMIT) begin
         cols_eff = COL_LIMIT;
      end else begin
         cols_eff = col_count_ff;
      end
   end

   // The position is saturated to the grid in case the counts shrank mid-grid.
   always_comb begin
      if ({1'b0, row_pos_ff} >= rows_eff) begin
         r_eff = ROW_BITS'(rows_eff - ROW_CNT_BITS'(1));
      end else begin
         r_eff = row_pos_ff;
      end
      if ({1'b0, col_pos_ff} >= cols_eff) begin
         c_eff = COL_BITS'(cols_eff - COL_CNT_BITS'(1));
      end else begin
         c_eff = col_pos_ff;
      end
   end

   assign c_eff_next = {1'b0, c_eff} + COL_CNT_BITS'(1);
   assign r_eff_next = {1'b0, r_eff} + ROW_CNT_BITS'(1);
   assign c_ff_next  = {1'b0, c_ff} + COL_CNT_BITS'(1);
   assign has_right  = c_ff_next < cols_eff;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && (state_ff == S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // During the last-row sweep there is no row below, so down reads as zero.
   always_comb begin
      nbr.center = ram_rd_data_a.mid;
      nbr.up     = ram_rd_data_a.up;
      nbr.down   = (state_ff == S_EVAL) ? x_ff : '0;
      nbr.left   = (c_ff != '0) ? left_ff : '0;
      nbr.right  = has_right ? ram_rd_data_b.mid : '0;
   end

   assign hit_row = hit && (r_ff != '0);

   always_comb begin
      ram_wr_data.up  = (r_ff == '0) ? '0 : ram_rd_data_a.mid;
      ram_wr_data.mid = x_ff;
   end

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      last_grid_in  = last_grid_ff;
      left_in       = left_ff;
      row_pos_in    = row_pos_ff;
      col_pos_in    = col_pos_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_last_in   = rsp_last_ff;
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr_a = c_ff;
      ram_rd_addr_b = c_ff_next[COL_BITS-1:0];

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_write_data[ROW_CNT_BITS-1:0];
            CSR_COL_COUNT: col_count_in = csr_write_data[COL_CNT_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in          = req_chan.pixel_value;
               r_in          = r_eff;
               c_in          = c_eff;
               ram_rd_en     = 1'b1;
               ram_rd_addr_a = c_eff;
               ram_rd_addr_b = c_eff_next[COL_BITS-1:0];
               last_grid_in  = 1'b0;
               if (c_eff_next < cols_eff) begin
                  row_pos_in = r_eff;
                  col_pos_in = c_eff_next[COL_BITS-1:0];
               end else if (r_eff_next < rows_eff) begin
                  row_pos_in = r_eff_next[ROW_BITS-1:0];
                  col_pos_in = '0;
               end else begin
                  row_pos_in   = '0;
                  col_pos_in   = '0;
                  last_grid_in = 1'b1;
               end
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (last_grid_ff) begin
               // Hold this result back: the sweep decides which result is last.
               ram_wr_en     = 1'b1;
               pend_valid_in = hit_row;
               pend_row_in   = r_ff - ROW_BITS'(1);
               pend_col_in   = c_ff;
               left_in       = ram_rd_data_a.mid;
               c_in          = '0;
               state_in      = S_FREAD;
            end else if (!hit_row || out_free) begin
               ram_wr_en = 1'b1;
               if (hit_row) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = r_ff - ROW_BITS'(1);
                  rsp_col_in   = c_ff;
                  rsp_last_in  = 1'b1;
               end
               left_in  = ram_rd_data_a.mid;
               state_in = S_IDLE;
            end
         end
         S_FREAD: begin
            ram_rd_en = 1'b1;
            state_in  = S_FEVAL;
         end
         S_FEVAL: begin
            if (!(hit && pend_valid_ff && !out_free)) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_row_in   = pend_row_ff;
                     rsp_col_in   = pend_col_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_row_in   = r_ff;
                  pend_col_in   = c_ff;
               end
               left_in = ram_rd_data_a.mid;
               if (has_right) begin
                  c_in     = c_ff_next[COL_BITS-1:0];
                  state_in = S_FREAD;
               end else begin
                  state_in = S_FEND;
               end
            end
         end
         S_FEND: begin
            if (!pend_valid_ff) begin
               left_in  = '0;
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = pend_row_ff;
               rsp_col_in    = pend_col_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               left_in       = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         left_ff       <= '0;
         row_pos_ff    <= '0;
         col_pos_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         row_count_ff  <= ROW_CNT_BITS'(1);
         col_count_ff  <= COL_CNT_BITS'(1);
         last_grid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         left_ff       <= left_in;
         row_pos_ff    <= row_pos_in;
         col_pos_ff    <= col_pos_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         last_grid_ff  <= last_grid_in;
      end
      x_ff        <= x_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      pend_row_ff <= pend_row_in;
      pend_col_ff <= pend_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.peak_row    = rsp_row_ff;
   assign rsp_chan.peak_col    = rsp_col_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

endmodule

@@ sv/glpf_checker.sv @@
// Port-level checks of the grid local peak finder, attached by a bind statement.
// Depends on glpf_pkg and on the top level grid_local_peak_finder_core.
module glpf_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input glpf_pkg::row_type   peak_row,
   input glpf_pkg::col_type   peak_col,
   input logic                last_of_run
);
   import glpf_pkg::*;

   // Coming out of reset the block is ready and has no result waiting.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

   // After taking a sample the block drops ready while it works on it.
   a_two_cycle_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample taken in the cycle after a transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(peak_row) && $stable(peak_col) && $stable(last_of_run)))
      else $error("result changed while stalled");

endmodule

bind grid_local_peak_finder_core glpf_checker u_glpf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .peak_row    (rsp_chan.peak_row),
   .peak_col    (rsp_chan.peak_col),
   .last_of_run (rsp_chan.last_of_run)
);

@@ tb/grid_local_peak_finder_checker.sv @@
// Scoreboard for the grid local peak finder: follows the grid position and line buffers.
// It watches both channels and the csr_ port, and depends on glpf_pkg and glpf_channels.
`timescale 1ns / 100ps

module grid_local_peak_finder_checker (
   input  logic                                clock,
   input  logic                                reset,
   glpf_req_if                                 req_mon,
   glpf_rsp_if                                 rsp_mon,
   input  logic                                csr_write_en,
   input  logic [glpf_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [glpf_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output int                                  mismatch_count,
   output int                                  waiting_peaks
);
   import glpf_pkg::*;

   typedef struct packed {
      row_type row;
      col_type col;
      logic    last;
   } peak_type;

   peak_type                    peak_queue[$];
   sample_type                  upper_row[MAX_COLS];
   sample_type                  middle_row[MAX_COLS];
   sample_type                  left_sample;
   int                          row_at;
   int                          col_at;
   logic [ROW_CNT_BITS-1:0]     rows_reg;
   logic [COL_CNT_BITS-1:0]     cols_reg;
   int                          fails = 0;

   assign mismatch_count = fails;

   task automatic report_mismatch(input string what);
      $display("peak check at %0t: %s", $realtime, what);
      fails++;
   endtask

   function automatic bit dominates(input sample_type v, up, down, w, e);
      return v >= up && v >= down && v >= w && v >= e;
   endfunction

   // Advances the grid by one sample and queues the peaks that it decides.
   task automatic take_sample(input sample_type x);
      int         rows;
      int         cols;
      int         r;
      int         c;
      sample_type w;
      sample_type e;
      sample_type old;
      peak_type   found[$];
      rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
      cols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
      r = (row_at >= rows) ? rows - 1 : row_at;
      c = (col_at >= cols) ? cols - 1 : col_at;
      if (r >= 1) begin
         w = (c > 0) ? left_sample : '0;
         e = (c + 1 < cols) ? middle_row[c + 1] : '0;
         if (dominates(middle_row[c], upper_row[c], x, w, e))
            found.push_back(peak_type'{row_type'(r - 1), col_type'(c), 1'b0});
      end
      old = middle_row[c];
      left_sample = old;
      upper_row[c] = (r == 0) ? '0 : old;
      middle_row[c] = x;
      if (c + 1 < cols) begin
         row_at = r;
         col_at = c + 1;
      end else if (r + 1 < rows) begin
         row_at = r + 1;
         col_at = 0;
      end else begin
         // The final sample settles the whole last row, with zero below it.
         for (int k = 0; k < cols; k++) begin
            w = (k > 0) ? middle_row[k - 1] : '0;
            e = (k + 1 < cols) ? middle_row[k + 1] : '0;
            if (dominates(middle_row[k], upper_row[k], '0, w, e))
               found.push_back(peak_type'{row_type'(r), col_type'(k), 1'b0});
         end
         row_at = 0;
         col_at = 0;
         left_sample = '0;
      end
      if (found.size() > 0)
         found[found.size() - 1].last = 1'b1;
      foreach (found[i])
         peak_queue.push_back(found[i]);
   endtask

   always @(posedge clock) begin
      peak_type want;
      if (reset) begin
         peak_queue.delete();
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         left_sample = '0;
         row_at = 0;
         col_at = 0;
         rows_reg = 1;
         cols_reg = 1;
         waiting_peaks <= 0;
      end else begin
         // Results are checked before this edge's sample is predicted, as no
         // result can come out in the same transfer as the sample causing it.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (peak_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected peak (%0d,%0d) last %0b",
                  rsp_mon.peak_row, rsp_mon.peak_col, rsp_mon.last_of_run));
            end else begin
               want = peak_queue.pop_front();
               if (rsp_mon.peak_row !== want.row)
                  report_mismatch($sformatf("peak_row %0d, expected %0d",
                     rsp_mon.peak_row, want.row));
               if (rsp_mon.peak_col !== want.col)
                  report_mismatch($sformatf("peak_col %0d, expected %0d",
                     rsp_mon.peak_col, want.col));
               if (rsp_mon.last_of_run !== want.last)
                  report_mismatch($sformatf("last_of_run %0b, expected %0b at (%0d,%0d)",
                     rsp_mon.last_of_run, want.last, want.row, want.col));
            end
         end
         if (req_mon.valid && req_mon.ready)
            take_sample(req_mon.pixel_value);
         if (csr_write_en) begin
            if (csr_index == CSR_ROW_COUNT)
               rows_reg = csr_write_data[ROW_CNT_BITS-1:0];
            else if (csr_index == CSR_COL_COUNT)
               cols_reg = csr_write_data[COL_CNT_BITS-1:0];
         end
         waiting_peaks <= peak_queue.size();
      end
   end

endmodule

@@ tb/grid_local_peak_finder_core_test.sv @@
// Top of the grid local peak finder testbench: clock, reset, stimulus and verdict.
// Depends on glpf_pkg, glpf_channels, the core and grid_local_peak_finder_checker.
`timescale 1ns / 100ps

module grid_local_peak_finder_core_test;
   import glpf_pkg::*;

   localparam int RANDOM_ITEMS   = 430;
   localparam int PHASE_ITEMS    = 30;
   localparam int SETTLE_CYCLES  = 2 * MAX_COLS + 16;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_type;
   typedef enum int {FILL_RANDOM, FILL_SMALL, FILL_FLAT, FILL_EXTREME} fill_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;
   int                        src_idle_pct;
   int                        snk_stall_pct;
   int                        mismatches;
   int                        waiting_peaks;
   int                        quiet_cycles = 0;

   glpf_req_if req_bus();
   glpf_rsp_if rsp_bus();

   grid_local_peak_finder_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   grid_local_peak_finder_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatches),
      .waiting_peaks  (waiting_peaks)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // Ends the run when neither channel completes a transfer for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("grid_local_peak_finder_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Returns at the edge on which the sample is transferred, with valid still high.
   task automatic send_sample(input sample_type value);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_value <= value;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // The extra edge first lets the scoreboard's count catch up with the last transfer;
   // the settle then covers a last-row sweep that produced nothing.
   task automatic drain_and_settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (waiting_peaks != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] index, input int value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_write_data <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_grid(input int cells);
      fill_type   fill;
      sample_type level;
      fill = fill_type'($urandom_range(3));
      level = sample_type'(int'($urandom_range(5)) - 1);
      repeat (cells) begin
         case (fill)
            FILL_RANDOM: send_sample(sample_type'($urandom));
            FILL_SMALL:  send_sample(sample_type'(int'($urandom_range(6)) - 3));
            FILL_FLAT:   send_sample(level);
            default: begin
               case ($urandom_range(3))
                  0: send_sample(sample_type'(-32768));
                  1: send_sample(sample_type'(32767));
                  2: send_sample(sample_type'(0));
                  default: send_sample(sample_type'(-1));
               endcase
            end
         endcase
      end
   endtask

   initial begin
      int sent;
      int phase;
      int rows_raw;
      int cols_raw;
      int cells;
      int in_phase;
      req_bus.valid = 1'b0;
      req_bus.pixel_value = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_ROW_COUNT;
      csr_write_data = '0;
      src_idle_pct = 0;
      snk_stall_pct = 0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One-cell grids from the reset sizes: the sample beats, ties or loses to the zero border.
      send_sample(sample_type'(32767));
      send_sample(sample_type'(-32768));
      send_sample(sample_type'(0));
      drain_and_settle();
      // A count of zero behaves as one.
      write_reg(CSR_ROW_COUNT, 0);
      write_reg(CSR_COL_COUNT, 0);
      send_sample(sample_type'(5));
      send_sample(sample_type'(-1));
      drain_and_settle();
      write_reg(CSR_ROW_COUNT, 2);
      write_reg(CSR_COL_COUNT, 3);
      send_sample(sample_type'(32767));
      send_sample(sample_type'(-32768));
      send_sample(sample_type'(32767));
      send_sample(sample_type'(-32768));
      send_sample(sample_type'(32767));
      send_sample(sample_type'(-32768));
      drain_and_settle();
      // A single row with ties between neighbours.
      write_reg(CSR_ROW_COUNT, 1);
      write_reg(CSR_COL_COUNT, 4);
      send_sample(sample_type'(3));
      send_sample(sample_type'(3));
      send_sample(sample_type'(-2));
      send_sample(sample_type'(3));
      drain_and_settle();
      // Shrink both counts part way through a grid so that the position saturates.
      write_reg(CSR_ROW_COUNT, 3);
      write_reg(CSR_COL_COUNT, 4);
      send_sample(sample_type'(1));
      send_sample(sample_type'(4));
      send_sample(sample_type'(-7));
      send_sample(sample_type'(2));
      send_sample(sample_type'(0));
      send_sample(sample_type'(9));
      send_sample(sample_type'(9));
      drain_and_settle();
      write_reg(CSR_COL_COUNT, 2);
      send_sample(sample_type'(6));
      send_sample(sample_type'(-3));
      drain_and_settle();
      write_reg(CSR_ROW_COUNT, 2);
      send_sample(sample_type'(8));

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         drain_and_settle();
         case (idle_type'(phase % 4))
            IDLE_NONE: begin
               src_idle_pct = 0;
               snk_stall_pct = 0;
            end
            IDLE_SENDER: begin
               src_idle_pct = 68;
               snk_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               src_idle_pct = 0;
               snk_stall_pct = 68;
            end
            default: begin
               src_idle_pct = 11;
               snk_stall_pct = 11;
            end
         endcase
         // The first phases visit the largest sizes, with values above the limits
         // and a column value with its unused top bit set.
         case (phase)
            0: begin
               rows_raw = MAX_ROWS;
               cols_raw = 1;
            end
            1: begin
               rows_raw = 1;
               cols_raw = MAX_COLS;
            end
            2: begin
               rows_raw = 127;
               cols_raw = 'h41;
            end
            3: begin
               rows_raw = 2;
               cols_raw = 63;
            end
            default: begin
               case ($urandom_range(7))
                  0: begin
                     rows_raw = $urandom_range(127);
                     cols_raw = ($urandom_range(1) << 6) | $urandom_range(2);
                  end
                  1: begin
                     rows_raw = $urandom_range(3);
                     cols_raw = $urandom_range(127);
                  end
                  default: begin
                     rows_raw = $urandom_range(6);
                     cols_raw = ($urandom_range(1) << 6) | $urandom_range(6);
                  end
               endcase
            end
         endcase
         write_reg(CSR_ROW_COUNT, rows_raw);
         write_reg(CSR_COL_COUNT, cols_raw);
         cols_raw = cols_raw & ((1 << COL_CNT_BITS) - 1);
         cells = ((rows_raw == 0) ? 1 : ((rows_raw > MAX_ROWS) ? MAX_ROWS : rows_raw))
               * ((cols_raw == 0) ? 1 : ((cols_raw > MAX_COLS) ? MAX_COLS : cols_raw));
         in_phase = 0;
         while (in_phase < PHASE_ITEMS) begin
            send_grid(cells);
            in_phase += cells;
         end
         sent += in_phase;
         phase++;
      end

      drain_and_settle();
      if (mismatches == 0)
         $display("grid_local_peak_finder_core verification clean");
      else
         $display("grid_local_peak_finder_core verification failed");
      $finish;
   end

endmodule
